[sv/qss_pkg.sv]
// ----------------------------------------------------------------------------
// qss_pkg
// Shared widths, codes and default sizes for the quantile summary store.
// ----------------------------------------------------------------------------
package qss_pkg;

  localparam int DEPTH_DEFAULT   = 1024;
  localparam int VALUE_W_DEFAULT = 32;
  localparam int COUNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

  localparam int RANK_W   = 11;
  localparam int BUCKET_W = 10;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam logic [RANK_W-1:0] CAPACITY_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPRESS = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP      = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

[sv/qss_div.sv]
// ----------------------------------------------------------------------------
// qss_div
// Restoring divider, one quotient bit per cycle, for the compress rank step.
// ----------------------------------------------------------------------------
module qss_div #(
  parameter int DIVIDEND_W = qss_pkg::COUNT_W_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DIVIDEND_W-1:0]         dividend,
  input  logic [qss_pkg::BUCKET_W-1:0]  divisor,
  output logic                          done,
  output logic [DIVIDEND_W-1:0]         quotient,
  output logic [qss_pkg::BUCKET_W-1:0]  remainder
);

  localparam int BW     = qss_pkg::BUCKET_W;
  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic              active;
  logic [STEP_W-1:0] steps;
  logic [DIVIDEND_W-1:0] dq;
  logic [BW-1:0]     dr;
  logic [BW:0]       trial;
  logic              ge;

  assign trial = {dr, dq[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        steps  <= STEP_W'(DIVIDEND_W);
      end else if (active) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq <= dividend;
      dr <= '0;
    end else if (active) begin
      dq <= {dq[DIVIDEND_W-2:0], ge};
      dr <= ge ? BW'(trial - {1'b0, divisor}) : trial[BW-1:0];
    end
  end

  assign quotient  = dq;
  assign remainder = dr;

endmodule

[sv/quantile_summary_store.sv]
// ----------------------------------------------------------------------------
// quantile_summary_store
// Store of value tuples with rank bounds: insert, query by rank, compress.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// on the result ports for a single cycle with done high and cannot be held
// off. Insert answers straight from the idle state. A query on a sorted
// store reads the tuple at the rank directly when uncompressed and runs a
// binary search over the rank bounds when compressed. The first query or
// compress after inserts first runs an insertion sort over the n tuples,
// then rewrites the ranks. Compress adds a division of the tuple count by
// the bucket count and, per bucket, one step plus a lookup. The tuple
// memory gives one registered read and one write per cycle.
module quantile_summary_store #(
  parameter int SUMMARY_DEPTH = qss_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH   = qss_pkg::VALUE_W_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [qss_pkg::OP_W-1:0]      operation,
  input  logic [VALUE_WIDTH-1:0]        value,
  input  logic [qss_pkg::RANK_W-1:0]    query_rank,
  input  logic [qss_pkg::BUCKET_W-1:0]  buckets,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qss_pkg::RANK_W-1:0]    cfg_data,
  output logic                          done,
  output logic [qss_pkg::STATUS_W-1:0]  status,
  output logic [VALUE_WIDTH-1:0]        found_value,
  output logic [qss_pkg::RANK_W-1:0]    lower_bound,
  output logic [qss_pkg::RANK_W-1:0]    upper_bound,
  output logic [qss_pkg::RANK_W-1:0]    tuple_count
);

  localparam int RW    = qss_pkg::RANK_W;
  localparam int BW    = qss_pkg::BUCKET_W;
  localparam int IW    = $clog2(SUMMARY_DEPTH);
  localparam int CNT_W = $clog2(SUMMARY_DEPTH + 1);
  localparam int KW    = (CNT_W > RW) ? CNT_W : RW;
  localparam int AW    = IW + 1;
  localparam int MEM_D = 2 * SUMMARY_DEPTH;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_SORT_LD  = 15'b000000000000010,
    S_SORT_GET = 15'b000000000000100,
    S_SORT_RD  = 15'b000000000001000,
    S_SORT_CMP = 15'b000000000010000,
    S_RANK     = 15'b000000000100000,
    S_DIV      = 15'b000000001000000,
    S_CGEN     = 15'b000000010000000,
    S_LK_0     = 15'b000000100000000,
    S_LK_1     = 15'b000001000000000,
    S_LK_2     = 15'b000010000000000,
    S_SRCH_RD  = 15'b000100000000000,
    S_SRCH     = 15'b001000000000000,
    S_FETCH    = 15'b010000000000000,
    S_FETCH_W  = 15'b100000000000000
  } state_t;

  state_t state;

  // two banks: compress builds the new summary in the idle bank
  logic [VALUE_WIDTH-1:0] val_mem [MEM_D];
  logic [RW-1:0]          lo_mem  [MEM_D];
  logic [RW-1:0]          hi_mem  [MEM_D];

  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   we_val;
  logic                   we_rank;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic [RW-1:0]          wr_lo;
  logic [RW-1:0]          wr_hi;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [RW-1:0]          rd_lo;
  logic [RW-1:0]          rd_hi;

  logic             bank;
  logic [CNT_W-1:0] count;
  logic [RW-1:0]    cap_now;
  logic             sorted;
  logic             compressed;
  logic             is_cmp;

  logic [CNT_W-1:0]       i_s;
  logic [IW-1:0]          j;
  logic [VALUE_WIDTH-1:0] v;
  logic [KW-1:0]          lk_rank;
  logic [RW-1:0]          lo0;
  logic [RW-1:0]          hi0;
  logic [IW-1:0]          l;
  logic [IW-1:0]          r;
  logic [IW-1:0]          c;
  logic [IW-1:0]          idx;

  logic [BW-1:0]    b_reg;
  logic [CNT_W-1:0] q0;
  logic [BW-1:0]    r0;
  logic [CNT_W-1:0] qa;
  logic [BW-1:0]    ra;
  logic [BW:0]      ci;
  logic [CNT_W-1:0] prev;
  logic [CNT_W-1:0] n;

  logic             div_go;
  logic             div_done;
  logic [CNT_W-1:0] div_q;
  logic [BW-1:0]    div_r;

  logic             full;
  logic             gt;
  logic [IW-1:0]    cnt_m1;
  logic [CNT_W-1:0] cur_rank;
  logic [BW:0]      rsum;

  assign full     = (count >= CNT_W'(SUMMARY_DEPTH)) || (KW'(count) >= KW'(cap_now));
  assign gt       = $signed(rd_val) > $signed(v);
  assign cnt_m1   = IW'(count - 1'b1);
  assign cur_rank = (ci == '0) ? CNT_W'(1) : qa;
  assign rsum     = {1'b0, ra} + {1'b0, r0};
  assign busy     = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  qss_div #(
    .DIVIDEND_W (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_go),
    .dividend  (count),
    .divisor   (b_reg),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    rd_addr = {bank, IW'(0)};
    wr_addr = {bank, j};
    we_val  = 1'b0;
    we_rank = 1'b0;
    wr_val  = v;
    wr_lo   = '0;
    wr_hi   = '0;
    case (state)
      S_IDLE: begin
        wr_addr = {bank, count[IW-1:0]};
        wr_val  = value;
        if (start && operation == qss_pkg::OP_INSERT && !full) begin
          we_val  = 1'b1;
          we_rank = 1'b1;
        end
      end
      S_SORT_LD: rd_addr = {bank, i_s[IW-1:0]};
      S_SORT_RD: begin
        rd_addr = {bank, IW'(j - 1'b1)};
        if (j == '0) begin
          we_val = 1'b1;
        end
      end
      S_SORT_CMP: begin
        we_val = 1'b1;
        wr_val = gt ? rd_val : v;
      end
      S_RANK: begin
        wr_addr = {bank, i_s[IW-1:0]};
        wr_lo   = RW'(i_s + 1'b1);
        wr_hi   = RW'(i_s + 1'b1);
        we_rank = (i_s < count);
      end
      S_LK_0:    rd_addr = {bank, IW'(0)};
      S_LK_1:    rd_addr = {bank, cnt_m1};
      S_SRCH_RD: rd_addr = {bank, c};
      S_FETCH:   rd_addr = {bank, idx};
      S_FETCH_W: begin
        wr_addr = {~bank, n[IW-1:0]};
        wr_val  = rd_val;
        wr_lo   = rd_lo;
        wr_hi   = rd_hi;
        if (is_cmp && n < CNT_W'(SUMMARY_DEPTH)) begin
          we_val  = 1'b1;
          we_rank = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_val) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (we_rank) begin
      lo_mem[wr_addr] <= wr_lo;
      hi_mem[wr_addr] <= wr_hi;
    end
    rd_val <= val_mem[rd_addr];
    rd_lo  <= lo_mem[rd_addr];
    rd_hi  <= hi_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bank       <= 1'b0;
      count      <= '0;
      cap_now    <= qss_pkg::CAPACITY_RESET;
      sorted     <= 1'b0;
      compressed <= 1'b0;
      is_cmp     <= 1'b0;
      done       <= 1'b0;
      div_go     <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      if (cfg_valid) begin
        cap_now <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          status      <= qss_pkg::ST_OK;
          found_value <= '0;
          lower_bound <= '0;
          upper_bound <= '0;
          tuple_count <= RW'(count);
          if (start) begin
            case (operation)
              qss_pkg::OP_INSERT: begin
                done <= 1'b1;
                if (full) begin
                  status <= qss_pkg::ST_FULL;
                end else begin
                  count       <= count + 1'b1;
                  sorted      <= 1'b0;
                  tuple_count <= RW'(count + 1'b1);
                end
              end
              qss_pkg::OP_QUERY, qss_pkg::OP_COMPRESS: begin
                if (operation == qss_pkg::OP_COMPRESS && buckets == '0) begin
                  done <= 1'b1;
                end else begin
                  is_cmp  <= (operation == qss_pkg::OP_COMPRESS);
                  b_reg   <= buckets;
                  lk_rank <= KW'(query_rank);
                  if (sorted) begin
                    if (operation == qss_pkg::OP_COMPRESS) begin
                      div_go <= 1'b1;
                      state  <= S_DIV;
                    end else begin
                      state <= S_LK_0;
                    end
                  end else if (count >= CNT_W'(2)) begin
                    i_s   <= CNT_W'(1);
                    state <= S_SORT_LD;
                  end else begin
                    i_s   <= '0;
                    state <= S_RANK;
                  end
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_SORT_LD: state <= S_SORT_GET;
        S_SORT_GET: begin
          v     <= rd_val;
          j     <= i_s[IW-1:0];
          state <= S_SORT_RD;
        end
        S_SORT_RD: begin
          if (j == '0) begin
            i_s   <= i_s + 1'b1;
            state <= S_SORT_LD;
            if (i_s + 1'b1 >= count) begin
              i_s   <= '0;
              state <= S_RANK;
            end
          end else begin
            state <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (gt) begin
            j     <= j - 1'b1;
            state <= S_SORT_RD;
          end else begin
            i_s   <= i_s + 1'b1;
            state <= S_SORT_LD;
            if (i_s + 1'b1 >= count) begin
              i_s   <= '0;
              state <= S_RANK;
            end
          end
        end
        S_RANK: begin
          if (i_s < count) begin
            i_s <= i_s + 1'b1;
          end else begin
            sorted <= 1'b1;
            if (is_cmp) begin
              div_go <= 1'b1;
              state  <= S_DIV;
            end else begin
              state <= S_LK_0;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            q0    <= div_q;
            r0    <= div_r;
            qa    <= '0;
            ra    <= '0;
            ci    <= '0;
            prev  <= '0;
            n     <= '0;
            state <= S_CGEN;
          end
        end
        S_CGEN: begin
          if (ci > {1'b0, b_reg}) begin
            count       <= n;
            cap_now     <= RW'({1'b0, b_reg} + 1'b1);
            compressed  <= 1'b1;
            bank        <= ~bank;
            done        <= 1'b1;
            status      <= qss_pkg::ST_OK;
            found_value <= '0;
            lower_bound <= '0;
            upper_bound <= '0;
            tuple_count <= RW'(n);
            state       <= S_IDLE;
          end else begin
            ci <= ci + 1'b1;
            if (rsum >= {1'b0, b_reg}) begin
              ra <= BW'(rsum - {1'b0, b_reg});
              qa <= qa + q0 + 1'b1;
            end else begin
              ra <= rsum[BW-1:0];
              qa <= qa + q0;
            end
            if (cur_rank != prev && cur_rank != '0) begin
              prev    <= cur_rank;
              lk_rank <= KW'(cur_rank);
              state   <= S_LK_0;
            end
          end
        end
        S_LK_0: begin
          if (count == '0) begin
            state <= is_cmp ? S_CGEN : S_IDLE;
            if (!is_cmp) begin
              done        <= 1'b1;
              status      <= qss_pkg::ST_NOT_FOUND;
              found_value <= '0;
              lower_bound <= '0;
              upper_bound <= '0;
              tuple_count <= RW'(count);
            end
          end else if (!compressed) begin
            if (lk_rank == '0 || lk_rank > KW'(count)) begin
              state <= is_cmp ? S_CGEN : S_IDLE;
              if (!is_cmp) begin
                done        <= 1'b1;
                status      <= qss_pkg::ST_NOT_FOUND;
                found_value <= '0;
                lower_bound <= '0;
                upper_bound <= '0;
                tuple_count <= RW'(count);
              end
            end else begin
              idx   <= IW'(lk_rank - 1'b1);
              state <= S_FETCH;
            end
          end else begin
            state <= S_LK_1;
          end
        end
        S_LK_1: begin
          lo0   <= rd_lo;
          hi0   <= rd_hi;
          state <= S_LK_2;
        end
        S_LK_2: begin
          if (lk_rank < KW'(lo0) || lk_rank > KW'(rd_hi)) begin
            state <= is_cmp ? S_CGEN : S_IDLE;
            if (!is_cmp) begin
              done        <= 1'b1;
              status      <= qss_pkg::ST_NOT_FOUND;
              found_value <= '0;
              lower_bound <= '0;
              upper_bound <= '0;
              tuple_count <= RW'(count);
            end
          end else if (lk_rank <= KW'(hi0)) begin
            idx   <= '0;
            state <= S_FETCH;
          end else if (lk_rank >= KW'(rd_lo)) begin
            idx   <= cnt_m1;
            state <= S_FETCH;
          end else begin
            l     <= '0;
            r     <= cnt_m1;
            c     <= cnt_m1 >> 1;
            state <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: state <= S_SRCH;
        S_SRCH: begin
          if (lk_rank < KW'(rd_lo)) begin
            if (c - l <= IW'(1)) begin
              idx   <= c;
              state <= S_FETCH;
            end else begin
              r     <= c;
              c     <= l + ((c - l) >> 1);
              state <= S_SRCH_RD;
            end
          end else if (lk_rank > KW'(rd_hi)) begin
            if (r - c <= IW'(1)) begin
              idx   <= c + 1'b1;
              state <= S_FETCH;
            end else begin
              l     <= c;
              c     <= c + ((r - c) >> 1);
              state <= S_SRCH_RD;
            end
          end else begin
            idx   <= c;
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_FETCH_W;
        S_FETCH_W: begin
          if (is_cmp) begin
            if (n < CNT_W'(SUMMARY_DEPTH)) begin
              n <= n + 1'b1;
            end
            state <= S_CGEN;
          end else begin
            done        <= 1'b1;
            status      <= qss_pkg::ST_OK;
            found_value <= rd_val;
            lower_bound <= rd_lo;
            upper_bound <= rd_hi;
            tuple_count <= RW'(count);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_insert_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == qss_pkg::OP_INSERT) |=> done)
    else $error("insert did not answer in one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SUMMARY_DEPTH))
    else $error("tuple count beyond depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != qss_pkg::ST_OK) |-> (lower_bound == '0 && upper_bound == '0))
    else $error("failed result carries rank bounds");

  a_compress_flag: assert property (@(posedge clk) disable iff (rst)
    (done && $past(state == S_CGEN)) |-> compressed)
    else $error("compress finished without marking the store");

  a_sorted_on_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> sorted)
    else $error("lookup on an unsorted store");

endmodule
